>>> design/sart_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted address range table.
// Used by every module of the block; depends on nothing else.
package sart_pkg;

  localparam int MAX_REGIONS_DEF = 64;
  localparam int ADDR_W          = 64;
  localparam int SLOT_OUT_W      = 6;
  localparam int IN_TDATA_W      = 3 * ADDR_W;
  localparam int OUT_TDATA_W     = 8;

  typedef enum logic [0:0] {
    FUNC_INSERT = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  // One stored region: start and exclusive end (start + length, wrapped)
  typedef struct packed {
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] end_addr;
  } region_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic              insert_en;
    logic [ADDR_W-1:0] new_start;
    logic [ADDR_W-1:0] new_end;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

endpackage

>>> design/sart_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted row: holds the region at one position of the end order.
// Depends on sart_pkg for the region and command types.
module sart_cell #(
  parameter int MAX_REGIONS = sart_pkg::MAX_REGIONS_DEF,
  parameter int INDEX       = 0,
  parameter int SLOT_W      = $clog2(MAX_REGIONS),
  parameter int CNT_W       = $clog2(MAX_REGIONS + 1)
) (
  input  logic                  clk,
  input  logic [CNT_W-1:0]      count,
  input  sart_pkg::cmd_t        cmd,
  input  logic [SLOT_W-1:0]     new_slot,
  input  sart_pkg::region_t     left_data,
  input  logic [SLOT_W-1:0]     left_slot,
  input  logic                  left_shift,
  input  logic                  left_look,
  output sart_pkg::region_t     data,
  output logic [SLOT_W-1:0]     slot,
  output logic                  shift,
  output logic                  look,
  output logic                  match
);

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  logic occupied;

  assign occupied = IDX < count;
  // entries with a larger end move one place right on an insert
  assign shift    = occupied && (cmd.new_end < data.end_addr);
  assign look     = occupied && (cmd.addr < data.end_addr);

  always_ff @(posedge clk) begin
    if (cmd.insert_en) begin
      if (left_shift) begin
        data <= left_data;
        slot <= left_slot;
      end else if (shift || (IDX == count)) begin
        data.start_addr <= cmd.new_start;
        data.end_addr   <= cmd.new_end;
        slot            <= new_slot;
      end
    end
    // first position whose end exceeds the address, and the address is not below its start
    match <= look && !left_look && (data.start_addr <= cmd.addr);
  end

endmodule

>>> design/sart_reduce.sv
`timescale 1ns / 1ps
// Collects the one-hot match flags of the cell row into a hit flag and a slot.
// Depends on sart_pkg for the address width.
module sart_reduce #(
  parameter int MAX_REGIONS = sart_pkg::MAX_REGIONS_DEF,
  parameter int SLOT_W      = $clog2(MAX_REGIONS)
) (
  input  logic [MAX_REGIONS-1:0]             match,
  input  logic [MAX_REGIONS-1:0][SLOT_W-1:0] slots,
  input  logic [sart_pkg::ADDR_W-1:0]        first_start,
  input  logic [sart_pkg::ADDR_W-1:0]        addr,
  output logic                               hit,
  output logic [SLOT_W-1:0]                  slot
);

  logic [SLOT_W-1:0] slot_or;

  always_comb begin
    slot_or = '0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      slot_or = slot_or | (slots[i] & {SLOT_W{match[i]}});
    end
  end

  // an address below the first ordered start misses even if a later entry covers it
  assign hit  = (|match) && !(first_start > addr);
  assign slot = slot_or;

endmodule

>>> design/sorted_address_range_table.sv
`timescale 1ns / 1ps
// Sorted address range table: stores regions and finds the region holding an address.
// Depends on sart_pkg, sart_cell and sart_reduce.
//
// Input channel s_*: one word per command. s_tuser selects insert or lookup.
// An insert stores start and start+length in the next free slot and keeps the
// row of cells ordered by end address; a full table answers status full.
// A lookup answers the slot of the region holding the address, or a miss.
// Output channel m_*: one word per command, status and slot.
// The command is latched at acceptance; in the next cycle all cells compare
// against it in parallel (and shift right on an insert once the output is free).
// An insert writes its output word from the execute state, a lookup from the
// scan state that collects the matching cell. One command is in flight at a time.
// The output register holds a finished word while m_tready is low; the next
// command is accepted meanwhile but waits to finish until that word leaves.
// Reset empties the table and drops any pending output word.
module sorted_address_range_table #(
  parameter int MAX_REGIONS = sart_pkg::MAX_REGIONS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // start_address [63:0], region_length [127:64], lookup_address [191:128]
  input  logic [sart_pkg::IN_TDATA_W-1:0]  s_tdata,
  // func [0]
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // status [1:0], slot_number [7:2]
  output logic [sart_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int SLOT_W = $clog2(MAX_REGIONS);
  localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
  localparam int AW     = sart_pkg::ADDR_W;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_REGIONS);

  sart_pkg::state_t  state, state_next;
  sart_pkg::func_t   func;
  logic [AW-1:0]     new_start;
  logic [AW-1:0]     new_end;
  logic [AW-1:0]     addr;
  logic [CNT_W-1:0]  count;

  sart_pkg::cmd_t    cmd;
  logic              out_free;
  logic              full;
  logic              out_write;
  sart_pkg::status_t out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [SLOT_W+sart_pkg::SLOT_OUT_W-1:0] slot_wide;

  sart_pkg::region_t                 cell_data  [MAX_REGIONS];
  sart_pkg::region_t                 left_data  [MAX_REGIONS];
  logic [MAX_REGIONS-1:0][SLOT_W-1:0] cell_slot;
  logic [MAX_REGIONS-1:0][SLOT_W-1:0] left_slot;
  logic [MAX_REGIONS-1:0]            cell_shift;
  logic [MAX_REGIONS-1:0]            left_shift;
  logic [MAX_REGIONS-1:0]            cell_look;
  logic [MAX_REGIONS-1:0]            left_look;
  logic [MAX_REGIONS-1:0]            cell_match;
  logic                              hit;
  logic [SLOT_W-1:0]                 hit_slot;

  assign s_tready = (state == sart_pkg::S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign full     = (count == FULL_COUNT);

  assign cmd.insert_en = (state == sart_pkg::S_EXEC) && (func == sart_pkg::FUNC_INSERT) &&
                         out_free && !full;
  assign cmd.new_start = new_start;
  assign cmd.new_end   = new_end;
  assign cmd.addr      = addr;

  // command register
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func      <= sart_pkg::func_t'(s_tuser);
      new_start <= s_tdata[AW-1:0];
      new_end   <= s_tdata[AW-1:0] + s_tdata[2*AW-1:AW];
      addr      <= s_tdata[3*AW-1:2*AW];
    end
  end

  generate
    for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
      if (i == 0) begin : g_head
        assign left_data[i]  = cell_data[i];
        assign left_slot[i]  = cell_slot[i];
        assign left_shift[i] = 1'b0;
        assign left_look[i]  = 1'b0;
      end else begin : g_link
        assign left_data[i]  = cell_data[i-1];
        assign left_slot[i]  = cell_slot[i-1];
        assign left_shift[i] = cell_shift[i-1];
        assign left_look[i]  = cell_look[i-1];
      end

      sart_cell #(
        .MAX_REGIONS (MAX_REGIONS),
        .INDEX       (i),
        .SLOT_W      (SLOT_W),
        .CNT_W       (CNT_W)
      ) u_cell (
        .clk        (clk),
        .count      (count),
        .cmd        (cmd),
        .new_slot   (count[SLOT_W-1:0]),
        .left_data  (left_data[i]),
        .left_slot  (left_slot[i]),
        .left_shift (left_shift[i]),
        .left_look  (left_look[i]),
        .data       (cell_data[i]),
        .slot       (cell_slot[i]),
        .shift      (cell_shift[i]),
        .look       (cell_look[i]),
        .match      (cell_match[i])
      );
    end
  endgenerate

  sart_reduce #(
    .MAX_REGIONS (MAX_REGIONS),
    .SLOT_W      (SLOT_W)
  ) u_reduce (
    .match       (cell_match),
    .slots       (cell_slot),
    .first_start (cell_data[0].start_addr),
    .addr        (addr),
    .hit         (hit),
    .slot        (hit_slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sart_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (cmd.insert_en) begin
        count <= count + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    out_write  = 1'b0;
    out_status = sart_pkg::ST_MISS;
    out_slot   = '0;
    unique case (state)
      sart_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = sart_pkg::S_EXEC;
        end
      end
      sart_pkg::S_EXEC: begin
        if (func == sart_pkg::FUNC_LOOKUP) begin
          state_next = sart_pkg::S_SCAN;
        end else if (out_free) begin
          out_write  = 1'b1;
          state_next = sart_pkg::S_IDLE;
          if (full) begin
            out_status = sart_pkg::ST_FULL;
          end else begin
            out_status = sart_pkg::ST_OK;
            out_slot   = count[SLOT_W-1:0];
          end
        end
      end
      sart_pkg::S_SCAN: begin
        if (out_free) begin
          out_write  = 1'b1;
          state_next = sart_pkg::S_IDLE;
          if (hit) begin
            out_status = sart_pkg::ST_OK;
            out_slot   = hit_slot;
          end
        end
      end
      default: begin
        state_next = sart_pkg::S_IDLE;
      end
    endcase
  end

  assign slot_wide = {{sart_pkg::SLOT_OUT_W{1'b0}}, out_slot};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_write) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_write) begin
      m_tdata <= {slot_wide[sart_pkg::SLOT_OUT_W-1:0], out_status};
    end
  end

endmodule

>>> design/sart_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the sorted address range table, bound to the top level.
// Depends on sart_pkg for widths and status codes.
module sart_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [sart_pkg::IN_TDATA_W-1:0]  s_tdata,
  input logic                             s_tuser,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [sart_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // a waiting word stays put until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == sart_pkg::ST_OK) || (m_tdata[1:0] == sart_pkg::ST_MISS) ||
                 (m_tdata[1:0] == sart_pkg::ST_FULL))
    else $error("unknown status code");

  a_miss_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != sart_pkg::ST_OK) |-> (m_tdata[7:2] == '0))
    else $error("miss or full word carries a slot");

  // one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second command taken while busy");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output word present after reset");

endmodule

bind sorted_address_range_table sart_checker u_sart_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
